// ===== rtl/mecanum_packet_odometry_defines.svh =====
// Assertion macros used by the odometry back end (mpo_back).
`ifndef MECANUM_PACKET_ODOMETRY_DEFINES_SVH
`define MECANUM_PACKET_ODOMETRY_DEFINES_SVH

`ifndef SYNTHESIS
`define MPO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpo assertion failed");
`define MPO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpo assertion failed");
`else
`define MPO_ASSERT_IMP(lbl, ante, cons)
`define MPO_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/mpo_pkg.sv =====
package mpo_pkg;

  localparam int PACKET_LEN = 18;
  localparam int CNT_W = $clog2(PACKET_LEN + 1);
  localparam int IDX_W = $clog2(PACKET_LEN);
  localparam int EL_W = 20;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_REFRESH = 1'b1;
  localparam logic [7:0] HDR_FIRST = 8'h02;
  localparam logic [7:0] HDR_SECOND = 8'h03;

  localparam logic [31:0] KP = 32'd2829695101;
  localparam logic [31:0] KU = 32'd2251799814;
  localparam logic [31:0] KH = 32'd2867080570;

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  localparam int MUL_B_W = 32;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam int DIV_STEPS = 44;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_AXLE   = 2'd1,
    CFG_XGAIN  = 2'd2,
    CFG_HGAIN  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [EL_W-1:0]              elapsed;
    logic [PACKET_LEN-1:0][7:0]   pkt;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  function automatic logic [29:0] atan_val(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10680862;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mpo_if.sv =====
interface mpo_cmd_if;
  import mpo_pkg::*;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [7:0]      rx_byte;
  logic [EL_W-1:0] elapsed_us;
  modport source(output valid, operation, rx_byte, elapsed_us, input ready);
  modport sink(input valid, operation, rx_byte, elapsed_us, output ready);
endinterface

interface mpo_odom_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic [15:0]        battery_tenths;
  modport source(output valid, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
                 battery_tenths, input ready);
  modport sink(input valid, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
               battery_tenths, output ready);
endinterface

interface mpo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/mpo_front.sv =====
module mpo_front (
  input  logic          clk,
  input  logic          rst,
  mpo_cmd_if.sink       cmd,
  output mpo_pkg::q_wr_t qw,
  input  logic          q_full
);
  import mpo_pkg::*;

  logic [7:0]                 previous_byte;
  logic [CNT_W-1:0]           byte_count;
  logic                       packet_ready;
  logic [PACKET_LEN-1:0][7:0] store;
  logic                       accept;
  logic                       header;
  logic                       room;

  assign cmd.ready = !q_full;
  assign accept = cmd.valid && cmd.ready;
  assign header = (previous_byte == HDR_FIRST) && (cmd.rx_byte == HDR_SECOND);
  assign room = byte_count < CNT_W'(PACKET_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte <= '0;
      byte_count <= '0;
      packet_ready <= 1'b0;
    end else if (accept) begin
      if (cmd.operation == OP_BYTE) begin
        previous_byte <= cmd.rx_byte;
        if (header) begin
          byte_count <= '0;
        end else if (room) begin
          byte_count <= byte_count + 1'b1;
          if (byte_count == CNT_W'(PACKET_LEN - 1)) packet_ready <= 1'b1;
        end
      end else if (packet_ready) begin
        packet_ready <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.operation == OP_BYTE && !header && room) begin
      store[byte_count[IDX_W-1:0]] <= cmd.rx_byte;
    end
  end

  assign qw.push = accept && (cmd.operation == OP_REFRESH) && packet_ready;
  assign qw.job.elapsed = cmd.elapsed_us;
  assign qw.job.pkt = store;

endmodule

// ===== rtl/mpo_fifo.sv =====
module mpo_fifo (
  input  logic           clk,
  input  logic           rst,
  input  mpo_pkg::q_wr_t qw,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output mpo_pkg::job_t  head
);
  import mpo_pkg::*;

  job_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wp;
  logic [Q_AW-1:0] rp;
  logic [Q_AW:0]   count;

  assign full = count == (Q_AW+1)'(Q_DEPTH);
  assign nonempty = count != '0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (qw.push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (qw.push && !pop) count <= count + 1'b1;
      else if (pop && !qw.push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (qw.push) mem[wp] <= qw.job;
  end

endmodule

// ===== rtl/mpo_mul.sv =====
module mpo_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [63:0]                  a,
  input  logic [mpo_pkg::MUL_B_W-1:0]  b,
  output logic                         done,
  output logic [63+mpo_pkg::MUL_B_W:0] prod
);
  import mpo_pkg::*;

  logic [63:0]          hi;
  logic [MUL_B_W-1:0]   lo;
  logic [63:0]          areg;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic [64:0]          t;

  assign t = {1'b0, hi} + (lo[0] ? {1'b0, areg} : 65'd0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= b;
      areg <= a;
    end else if (busy) begin
      hi <= t[64:1];
      lo <= {t[0], lo[MUL_B_W-1:1]};
    end
  end

endmodule

// ===== rtl/mpo_back.sv =====
`include "mecanum_packet_odometry_defines.svh"

module mpo_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mpo_pkg::job_t q_job,
  output logic          q_pop,
  mpo_odom_if.source    odom,
  mpo_cfg_if.sink       cfg
);
  import mpo_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_LOAD  = 24'h000002,
    S_AX    = 24'h000004,
    S_VX    = 24'h000008,
    S_AY    = 24'h000010,
    S_VY    = 24'h000020,
    S_AW    = 24'h000040,
    S_NW    = 24'h000080,
    S_DIV   = 24'h000100,
    S_CINIT = 24'h000200,
    S_CORD  = 24'h000400,
    S_XC    = 24'h000800,
    S_YS    = 24'h001000,
    S_DEX   = 24'h002000,
    S_KUX   = 24'h004000,
    S_GX    = 24'h008000,
    S_XS    = 24'h010000,
    S_YC    = 24'h020000,
    S_DEY   = 24'h040000,
    S_KUY   = 24'h080000,
    S_YE    = 24'h100000,
    S_KH    = 24'h200000,
    S_GH    = 24'h400000,
    S_UPD   = 24'h800000
  } state_t;

  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] HALF = 34'sd2147483648;
  localparam logic signed [48:0] P_MAX = 49'sd2147483647;
  localparam logic signed [48:0] P_MIN = -49'sd2147483648;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [31:0] abs34(input logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    return m[31:0];
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [34:0] wext(input logic [31:0] u);
    return 35'($signed(u));
  endfunction

  state_t state;

  logic [15:0] radius;
  logic [14:0] axle;
  logic [14:0] xgain;
  logic [14:0] hgain;
  logic [14:0] axl;

  job_t                jr;
  logic [EL_W-1:0]     elr;
  logic [15:0]         batt;
  logic signed [34:0]  sx, sy, sw;
  logic signed [34:0]  w1, w2, w3, w4;
  logic [63:0]         tm;
  logic                tneg;
  logic signed [31:0]  vx, vy, yaw;
  logic signed [33:0]  cx, cy, cz;
  logic signed [33:0]  cs, sn, hd;
  logic                flip;
  logic [STEP_W-1:0]   step;
  logic signed [63:0]  p1;
  logic signed [47:0]  dx, dy;
  logic [31:0]         dh;
  logic [DIV_STEPS-1:0] dq;
  logic [14:0]         rem;
  logic [15:0]         r2;
  logic [DIV_CNT_W-1:0] dcnt;

  logic signed [31:0]  pos_x, pos_y;
  logic [31:0]         heading_angle;
  logic                ov;

  logic                is_mul, mbusy, mstart, mdone, mneg;
  logic [63:0]         ma;
  logic [MUL_B_W-1:0]  mb;
  logic [95:0]         mprod;
  state_t              mnext;

  logic [95:0]         r53, r41, r51, r38, r14, r50d;
  logic [63:0]         plo, nw, dmag;
  logic signed [63:0]  pv, dsum;
  logic [31:0]         m14;
  logic signed [48:0]  sumx, sumy;
  logic signed [31:0]  nx, ny;
  logic [31:0]         nh;

  assign axl = (axle == '0) ? 15'd1 : axle;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd6652;
      axle <= 15'd2437;
      xgain <= 15'd16626;
      hgain <= 15'd16093;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_RADIUS: radius <= cfg.data;
        CFG_AXLE:   axle <= cfg.data[14:0];
        CFG_XGAIN:  xgain <= cfg.data[14:0];
        CFG_HGAIN:  hgain <= cfg.data[14:0];
        default:    radius <= radius;
      endcase
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  assign w1 = wext({jr.pkt[3], jr.pkt[2], jr.pkt[1], jr.pkt[0]});
  assign w2 = wext({jr.pkt[7], jr.pkt[6], jr.pkt[5], jr.pkt[4]});
  assign w3 = wext({jr.pkt[11], jr.pkt[10], jr.pkt[9], jr.pkt[8]});
  assign w4 = wext({jr.pkt[15], jr.pkt[14], jr.pkt[13], jr.pkt[12]});

  assign cs = flip ? -cx : cx;
  assign sn = flip ? -cy : cy;
  assign hd = 34'($signed(heading_angle));

  always_comb begin
    is_mul = 1'b1;
    ma = '0;
    mb = '0;
    mneg = 1'b0;
    mnext = S_IDLE;
    unique case (state)
      S_AX:  begin ma = abs64(64'(sx)); mb = 32'(radius); mneg = sx[34]; mnext = S_VX; end
      S_VX:  begin ma = tm; mb = KP; mneg = tneg; mnext = S_AY; end
      S_AY:  begin ma = abs64(64'(sy)); mb = 32'(radius); mneg = sy[34]; mnext = S_VY; end
      S_VY:  begin ma = tm; mb = KP; mneg = tneg; mnext = S_AW; end
      S_AW:  begin ma = abs64(64'(sw)); mb = 32'(radius); mneg = sw[34]; mnext = S_NW; end
      S_NW:  begin ma = tm; mb = KP; mneg = tneg; mnext = S_DIV; end
      S_XC:  begin ma = 64'(abs32(vx)); mb = abs34(cs); mneg = vx[31] ^ cs[33];
                   mnext = S_YS; end
      S_YS:  begin ma = 64'(abs32(vy)); mb = abs34(sn); mneg = vy[31] ^ sn[33];
                   mnext = S_DEX; end
      S_DEX: begin ma = tm; mb = 32'(elr); mneg = tneg; mnext = S_KUX; end
      S_KUX: begin ma = tm; mb = KU; mneg = tneg; mnext = S_GX; end
      S_GX:  begin ma = tm; mb = 32'(xgain); mneg = tneg; mnext = S_XS; end
      S_XS:  begin ma = 64'(abs32(vx)); mb = abs34(sn); mneg = vx[31] ^ sn[33];
                   mnext = S_YC; end
      S_YC:  begin ma = 64'(abs32(vy)); mb = abs34(cs); mneg = vy[31] ^ cs[33];
                   mnext = S_DEY; end
      S_DEY: begin ma = tm; mb = 32'(elr); mneg = tneg; mnext = S_KUY; end
      S_KUY: begin ma = tm; mb = KU; mneg = tneg; mnext = S_YE; end
      S_YE:  begin ma = 64'(abs32(yaw)); mb = 32'(elr); mneg = yaw[31]; mnext = S_KH; end
      S_KH:  begin ma = tm; mb = KH; mneg = tneg; mnext = S_GH; end
      S_GH:  begin ma = tm; mb = 32'(hgain); mneg = tneg; mnext = S_UPD; end
      default: is_mul = 1'b0;
    endcase
  end

  assign mstart = is_mul && !mbusy;

  mpo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .prod  (mprod)
  );

  assign r53 = (mprod + (96'd1 << 52)) >> 53;
  assign r41 = (mprod + (96'd1 << 40)) >> 41;
  assign r51 = (mprod + (96'd1 << 50)) >> 51;
  assign r50d = r51;
  assign r38 = (mprod + (96'd1 << 37)) >> 38;
  assign r14 = (mprod + (96'd1 << 13)) >> 14;
  assign plo = mprod[63:0];
  assign pv = mneg ? -$signed(plo) : $signed(plo);
  assign dsum = (state == S_YS) ? p1 - pv : p1 + pv;
  assign dmag = (abs64(dsum) + (64'd1 << 29)) >> 30;
  assign nw = r41[63:0];
  assign m14 = r14[31:0];
  assign r2 = {rem, dq[DIV_STEPS-1]};

  assign sumx = 49'(pos_x) + 49'(dx);
  assign sumy = 49'(pos_y) + 49'(dy);
  assign nx = (sumx > P_MAX) ? 32'sh7FFFFFFF : (sumx < P_MIN) ? 32'sh80000000 : 32'(sumx);
  assign ny = (sumy > P_MAX) ? 32'sh7FFFFFFF : (sumy < P_MIN) ? 32'sh80000000 : 32'(sumy);
  assign nh = heading_angle + dh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mbusy <= 1'b0;
      ov <= 1'b0;
      pos_x <= '0;
      pos_y <= '0;
      heading_angle <= '0;
    end else begin
      if (state == S_UPD && (!ov || odom.ready)) ov <= 1'b1;
      else if (ov && odom.ready) ov <= 1'b0;
      if (is_mul) begin
        if (!mbusy) begin
          mbusy <= 1'b1;
        end else if (mdone) begin
          mbusy <= 1'b0;
          state <= mnext;
        end
      end
      unique case (state)
        S_IDLE:  if (q_valid) state <= S_LOAD;
        S_LOAD:  state <= S_AX;
        S_DIV:   if (dcnt == DIV_CNT_W'(DIV_STEPS - 1)) state <= S_CINIT;
        S_CINIT: state <= S_CORD;
        S_CORD:  if (step == STEP_W'(CORDIC_STEPS - 1)) state <= S_XC;
        S_UPD: begin
          if (!ov || odom.ready) begin
            pos_x <= nx;
            pos_y <= ny;
            heading_angle <= nh;
            state <= S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) jr <= q_job;
    if (state == S_LOAD) begin
      elr <= jr.elapsed;
      batt <= {jr.pkt[16], jr.pkt[17]};
      sx <= w1 + w2 + w3 + w4;
      sy <= -w1 + w2 + w3 - w4;
      sw <= -w1 + w2 - w3 + w4;
    end
    if (mdone && mbusy) begin
      case (state)
        S_AX, S_AY, S_AW, S_DEX, S_DEY, S_YE: begin
          tm <= plo;
          tneg <= mneg;
        end
        S_VX: vx <= mneg ? -$signed(r53[31:0]) : $signed(r53[31:0]);
        S_VY: vy <= mneg ? -$signed(r53[31:0]) : $signed(r53[31:0]);
        S_NW: begin
          tneg <= mneg;
          dq <= nw[DIV_STEPS-1:0] + DIV_STEPS'(axl[14:1]);
          rem <= '0;
          dcnt <= '0;
        end
        S_XC, S_XS: p1 <= pv;
        S_YS, S_YC: begin
          tm <= dmag;
          tneg <= dsum[63];
        end
        S_KUX: begin
          tm <= r51[63:0];
          tneg <= mneg;
        end
        S_KH: begin
          tm <= r38[63:0];
          tneg <= mneg;
        end
        S_GX:  dx <= mneg ? -$signed(r14[47:0]) : $signed(r14[47:0]);
        S_KUY: dy <= mneg ? -$signed(r50d[47:0]) : $signed(r50d[47:0]);
        S_GH:  dh <= mneg ? 32'(-m14) : m14;
        default: ;
      endcase
    end
    if (state == S_DIV) begin
      dcnt <= dcnt + 1'b1;
      if (r2 >= {1'b0, axl}) begin
        rem <= 15'(r2 - {1'b0, axl});
        dq <= {dq[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= r2[14:0];
        dq <= {dq[DIV_STEPS-2:0], 1'b0};
      end
    end
    if (state == S_CINIT) begin
      if (tneg) begin
        yaw <= (dq > DIV_STEPS'(64'd2147483648)) ? 32'sh80000000 : -$signed(dq[31:0]);
      end else begin
        yaw <= (dq > DIV_STEPS'(64'd2147483647)) ? 32'sh7FFFFFFF : $signed(dq[31:0]);
      end
      cx <= CORDIC_X0;
      cy <= '0;
      step <= '0;
      if (hd > QUARTER) begin
        cz <= hd - HALF;
        flip <= 1'b1;
      end else if (hd < -QUARTER) begin
        cz <= hd + HALF;
        flip <= 1'b1;
      end else begin
        cz <= hd;
        flip <= 1'b0;
      end
    end
    if (state == S_CORD) begin
      step <= step + 1'b1;
      if (!cz[33]) begin
        cx <= cx - (cy >>> step);
        cy <= cy + (cx >>> step);
        cz <= cz - $signed({4'b0, atan_val(step)});
      end else begin
        cx <= cx + (cy >>> step);
        cy <= cy - (cx >>> step);
        cz <= cz + $signed({4'b0, atan_val(step)});
      end
    end
    if (state == S_UPD && (!ov || odom.ready)) begin
      odom.pos_x <= nx;
      odom.pos_y <= ny;
      odom.heading <= nh;
      odom.vel_x <= vx;
      odom.vel_y <= vy;
      odom.yaw_rate <= yaw;
      odom.battery_tenths <= batt;
    end
  end

  assign odom.valid = ov;

  `MPO_ASSERT_IMP(a_pop_idle, q_pop, state == S_IDLE)
  `MPO_ASSERT_IMP(a_div_cnt, state == S_DIV, dcnt < DIV_CNT_W'(DIV_STEPS))
  `MPO_ASSERT_NEXT(a_upd_emit, state == S_UPD && (!ov || odom.ready), ov && state == S_IDLE)

endmodule

// ===== rtl/mecanum_packet_odometry.sv =====
// Byte transactions: one per cycle while the queue is not full; framing and
// packet store update together. Refresh with a ready packet: the back end
// computes 18 products on one shift-add multiplier, a 44-step divider and
// 28 CORDIC steps. A two-entry queue lets bytes keep flowing meanwhile.
// Reset (rst, synchronous): pose, framing state and queue clear; registers
// return to their defaults. The packet store is not cleared.
module mecanum_packet_odometry (
  input logic        clk,
  input logic        rst,
  mpo_cmd_if.sink    cmd,
  mpo_odom_if.source odom,
  mpo_cfg_if.sink    cfg
);
  import mpo_pkg::*;

  q_wr_t qw;
  logic  q_full;
  logic  q_nonempty;
  logic  q_pop;
  job_t  q_head;

  mpo_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .qw     (qw),
    .q_full (q_full)
  );

  mpo_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .qw       (qw),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  mpo_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_nonempty),
    .q_job   (q_head),
    .q_pop   (q_pop),
    .odom    (odom),
    .cfg     (cfg)
  );

endmodule

// ===== tb/mecanum_packet_odometry_tb.sv =====
`timescale 1ns / 1ps

module mecanum_packet_odometry_tb;
  import mpo_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic [15:0]        battery_tenths;
  } odom_t;

  class odom_scoreboard;
    logic [15:0]        radius;
    logic [14:0]        axle;
    logic [14:0]        x_gain;
    logic [14:0]        h_gain;
    logic [7:0]         last_byte;
    int unsigned        fill;
    logic [7:0]         pkt [PACKET_LEN];
    bit                 pkt_ready;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [31:0]        hdg;
    longint             atan_lut [28];
    odom_t              expected_odom [$];
    int                 errors;

    function new();
      atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                   81, 41, 20, 10, 5};
      errors = 0;
      radius = 6652;
      axle = 2437;
      x_gain = 16626;
      h_gain = 16093;
      last_byte = 0;
      fill = 0;
      pkt_ready = 0;
      x_pos = 0;
      y_pos = 0;
      hdg = 0;
      foreach (pkt[i]) pkt[i] = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] d);
      case (idx)
        CFG_RADIUS: radius = d;
        CFG_AXLE:   axle = d[14:0];
        CFG_XGAIN:  x_gain = d[14:0];
        CFG_HGAIN:  h_gain = d[14:0];
      endcase
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint round_shift(longint v, int n);
      longint unsigned m;
      m = (mag(v) + (64'd1 << (n - 1))) >> n;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint scale_mul(longint a, longint unsigned k, int sh);
      longint unsigned m, lo, hi, t;
      m = mag(a);
      lo = (m & 64'hFFFF_FFFF) * k;
      hi = (m >> 32) * k;
      t = (hi + (lo >> 32) + (64'd1 << (sh - 33))) >> (sh - 32);
      return a < 0 ? -longint'(t) : longint'(t);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void sin_cos(logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit flip;
      z = longint'($signed(ang));
      flip = 0;
      x = 652032874;
      y = 0;
      if (z > 64'sd1073741824) begin
        z -= 64'sd2147483648;
        flip = 1;
      end else if (z < -64'sd1073741824) begin
        z += 64'sd2147483648;
        flip = 1;
      end
      for (int i = 0; i < 28; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_lut[i];
        end else begin
          x += ys; y -= xs; z += atan_lut[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint wheel_count(int b);
      logic signed [31:0] u;
      u = {pkt[b+3], pkt[b+2], pkt[b+1], pkt[b]};
      return longint'(u);
    endfunction

    function void note_cmd(logic op, logic [7:0] b, logic [19:0] el);
      longint w1, w2, w3, w4, r, vx, vy, yaw, c, s, d, q, dx, dy, dh, n, ax;
      longint unsigned m;
      odom_t o;
      if (op == OP_BYTE) begin
        if (last_byte == HDR_FIRST && b == HDR_SECOND) begin
          last_byte = b;
          fill = 0;
          return;
        end
        last_byte = b;
        if (fill < PACKET_LEN) begin
          pkt[fill] = b;
          fill++;
          if (fill == PACKET_LEN) pkt_ready = 1;
        end
        return;
      end
      if (!pkt_ready) return;
      w1 = wheel_count(0); w2 = wheel_count(4); w3 = wheel_count(8); w4 = wheel_count(12);
      r = longint'(radius);
      ax = axle == 0 ? 64'sd1 : longint'(axle);
      vx = scale_mul((w1 + w2 + w3 + w4) * r, KP, 53);
      vy = scale_mul((-w1 + w2 + w3 - w4) * r, KP, 53);
      n = scale_mul((-w1 + w2 - w3 + w4) * r, KP, 41);
      m = (mag(n) + ax / 2) / ax;
      yaw = clamp32(n < 0 ? -longint'(m) : longint'(m));
      sin_cos(hdg, c, s);
      d = round_shift(vx * c - vy * s, 30);
      q = scale_mul(d * longint'(el), KU, 51);
      dx = round_shift(q * longint'(x_gain), 14);
      d = round_shift(vx * s + vy * c, 30);
      dy = scale_mul(d * longint'(el), KU, 51);
      dh = round_shift(scale_mul(yaw * longint'(el), KH, 38) * longint'(h_gain), 14);
      x_pos = 32'(clamp32(longint'(x_pos) + dx));
      y_pos = 32'(clamp32(longint'(y_pos) + dy));
      hdg = hdg + dh[31:0];
      pkt_ready = 0;
      o.pos_x = x_pos;
      o.pos_y = y_pos;
      o.heading = hdg;
      o.vel_x = vx[31:0];
      o.vel_y = vy[31:0];
      o.yaw_rate = yaw[31:0];
      o.battery_tenths = {pkt[16], pkt[17]};
      expected_odom.push_back(o);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s expected %0h actual %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_odom(odom_t got);
      odom_t e;
      if (expected_odom.size() == 0) begin
        $error("unexpected odometry transaction pos_x %0h", got.pos_x);
        errors++;
        return;
      end
      e = expected_odom.pop_front();
      cmp("pos_x", e.pos_x, got.pos_x);
      cmp("pos_y", e.pos_y, got.pos_y);
      cmp("heading", e.heading, got.heading);
      cmp("vel_x", e.vel_x, got.vel_x);
      cmp("vel_y", e.vel_y, got.vel_y);
      cmp("yaw_rate", e.yaw_rate, got.yaw_rate);
      cmp("battery_tenths", 32'(e.battery_tenths), 32'(got.battery_tenths));
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 800;

  logic clk;
  logic rst;
  bit   calm;
  int   idle_cycles;
  int   sent;
  odom_scoreboard sb;

  mpo_cmd_if  cmd ();
  mpo_odom_if odom ();
  mpo_cfg_if  cfg ();

  mecanum_packet_odometry dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd.sink),
    .odom (odom.source),
    .cfg  (cfg.sink)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    odom_t got;
    if (!rst && odom.valid && odom.ready) begin
      got.pos_x = odom.pos_x;
      got.pos_y = odom.pos_y;
      got.heading = odom.heading;
      got.vel_x = odom.vel_x;
      got.vel_y = odom.vel_y;
      got.yaw_rate = odom.yaw_rate;
      got.battery_tenths = odom.battery_tenths;
      sb.check_odom(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (odom.valid && odom.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    odom.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        odom.ready <= 1;
        @(posedge clk);
      end else begin
        odom.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  task automatic send_cmd(logic op, logic [7:0] b, logic [19:0] el);
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd.valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    cmd.valid <= 1;
    cmd.operation <= op;
    cmd.rx_byte <= b;
    cmd.elapsed_us <= el;
    do @(posedge clk); while (!cmd.ready);
    sb.note_cmd(op, b, el);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_cmd(OP_BYTE, b, 20'($urandom));
  endtask

  task automatic refresh(logic [19:0] el);
    send_cmd(OP_REFRESH, 8'($urandom), el);
  endtask

  task automatic send_packet(logic [31:0] w [4], logic [15:0] batt, int len);
    logic [7:0] body [$];
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 4; k++) body.push_back(w[i][8*k +: 8]);
    body.push_back(batt[15:8]);
    body.push_back(batt[7:0]);
    while (body.size() < len) body.push_back(8'($urandom));
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    for (int i = 0; i < len; i++) send_byte(body[i]);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [15:0] d);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, d);
  endtask

  task automatic wait_idle();
    cmd.valid <= 0;
    while (sb.expected_odom.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] r, logic [15:0] a, logic [15:0] xg, logic [15:0] hg);
    wait_idle();
    write_cfg(CFG_RADIUS, r);
    write_cfg(CFG_AXLE, a);
    write_cfg(CFG_XGAIN, xg);
    write_cfg(CFG_HGAIN, hg);
    cfg.valid <= 0;
  endtask

  function automatic logic [31:0] rand_wheel();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  function automatic logic [19:0] rand_elapsed();
    case ($urandom_range(0, 3))
      0: return 20'($urandom);
      default: return 20'($urandom_range(1000, 60000));
    endcase
  endfunction

  task automatic random_round();
    logic [31:0] w [4];
    int len;
    foreach (w[i]) w[i] = rand_wheel();
    repeat ($urandom_range(0, 9) < 2 ? $urandom_range(1, 4) : 0) send_byte(8'($urandom));
    case ($urandom_range(0, 9))
      0: len = $urandom_range(5, 17);
      1: len = $urandom_range(19, 22);
      default: len = PACKET_LEN;
    endcase
    send_packet(w, 16'($urandom), len);
    if ($urandom_range(0, 9) != 0) refresh(rand_elapsed());
    if ($urandom_range(0, 9) == 0) refresh(rand_elapsed());
  endtask

  initial begin
    logic [31:0] w [4];
    sb = new();
    clk = 0;
    rst = 1;
    calm = 0;
    sent = 0;
    idle_cycles = 0;
    cmd.valid = 0;
    cmd.operation = OP_BYTE;
    cmd.rx_byte = 0;
    cmd.elapsed_us = 0;
    cfg.valid = 0;
    cfg.index = CFG_RADIUS;
    cfg.data = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // no packet yet: refresh is ignored
    refresh(20'hFFFFF);
    w = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    send_packet(w, 16'hFFFF, PACKET_LEN + 2);
    refresh(20'hFFFFF);
    refresh(20'd1000);
    w = '{32'd1000, 32'd1000, 32'd1000, 32'd1000};
    send_packet(w, 16'h0000, PACKET_LEN);
    // header after ready: restart with a partial packet, old tail decoded
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'hFF);
    send_byte(8'h00);
    refresh(20'd0);

    set_regs(16'hFFFF, 16'd1, 16'h7FFF, 16'h7FFF);
    w = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_packet(w, 16'h00FF, PACKET_LEN);
    refresh(20'hFFFFF);
    set_regs(16'd1, 16'hFFFF, 16'd0, 16'd0);
    repeat (15) random_round();
    set_regs(16'd6652, 16'd0, 16'd16626, 16'd16093);
    repeat (15) random_round();
    set_regs(16'd6652, 16'd2437, 16'd16626, 16'd16093);
    while (sent < 900) random_round();
    set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 32767)),
             16'($urandom), 16'($urandom));
    while (sent < 1450) random_round();
    calm = 1;
    while (sent < 1750) random_round();

    wait_idle();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mpo_pkg.sv
rtl/mpo_if.sv
rtl/mpo_front.sv
rtl/mpo_fifo.sv
rtl/mpo_mul.sv
rtl/mpo_back.sv
rtl/mecanum_packet_odometry.sv
tb/mecanum_packet_odometry_tb.sv
